// ===== src/psl_pkg.sv =====
// shared types and constants for the positional sequential list
package psl_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned PosW     = 7;
  localparam int unsigned CmpW     = (CountW + 1 > PosW) ? CountW + 1 : PosW;

  localparam logic [1:0] KindGet    = 2'd0;
  localparam logic [1:0] KindInsert = 2'd1;
  localparam logic [1:0] KindDelete = 2'd2;
  localparam logic [1:0] KindSearch = 2'd3;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StRange   = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StMissing = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [PosW-1:0]    position;
    logic signed [31:0] key;
    logic [63:0]        payload;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [PosW-1:0]    found_position;
    logic signed [31:0] record_key;
    logic [63:0]        record_payload;
    logic [PosW-1:0]    count;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic [63:0]        payload;
  } entry_t;

endpackage

// ===== src/psl_ram.sv =====
// single write port, single registered read port record memory
module psl_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 96,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/positional_sequential_list.sv =====
// positional sequential list: sequencer walking the record memory one entry per cycle
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid_i/req_ready_o | psl_pkg::req_t
//   rsp     | out       | rsp_valid_o/rsp_ready_i | psl_pkg::rsp_t
//
// one request at a time; n is the count, p the position
// get reads p; insert shifts p..n up, delete p+1..n down; search scans 1..n to a hit
// the single read port of the record memory moves or compares one entry per cycle
// reset clears the count and handshake state; the memory needs no clearing
// a finished result waits in its own state while the output register is still full
module positional_sequential_list (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  psl_pkg::req_t req_i,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output psl_pkg::rsp_t rsp_o
);

  localparam logic [2:0] SIdle     = 3'd0;
  localparam logic [2:0] SGetWait  = 3'd1;
  localparam logic [2:0] SInsShift = 3'd2;
  localparam logic [2:0] SInsPut   = 3'd3;
  localparam logic [2:0] SDelShift = 3'd4;
  localparam logic [2:0] SSearch   = 3'd5;
  localparam logic [2:0] SReply    = 3'd6;

  localparam int unsigned EntryW = $bits(psl_pkg::entry_t);

  logic [2:0] state_q, state_d;
  logic [psl_pkg::AddrW-1:0] addr_q, addr_d;
  logic [psl_pkg::AddrW-1:0] lim_q, lim_d;
  logic [psl_pkg::CountW-1:0] fill_q, fill_d;
  logic [1:0] status_q, status_d;
  logic [psl_pkg::PosW-1:0] found_q, found_d;
  logic rec_ok_q, rec_ok_d;
  logic signed [31:0] key_q, key_d;
  logic [63:0] pay_q, pay_d;
  psl_pkg::rsp_t rsp_q, rsp_d;
  logic rsp_valid_q, rsp_valid_d;

  logic ram_we, ram_re;
  logic [psl_pkg::AddrW-1:0] ram_waddr, ram_raddr;
  psl_pkg::entry_t ram_wdata, rd_entry;
  logic [EntryW-1:0] ram_rdata;

  logic [psl_pkg::CmpW-1:0] pos_c, fill_c;
  logic [psl_pkg::AddrW-1:0] pos_m1, fill_m1, addr_p1, addr_m1;
  logic [psl_pkg::PosW-1:0] hit_pos;
  logic req_xfer, slot_free;

  psl_ram #(
    .Depth (psl_pkg::Capacity),
    .Width (EntryW),
    .AddrW (psl_pkg::AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry    = psl_pkg::entry_t'(ram_rdata);
  assign req_ready_o = (state_q == SIdle);
  assign req_xfer    = req_valid_i && req_ready_o;
  assign slot_free   = !rsp_valid_q || rsp_ready_i;

  assign pos_c   = psl_pkg::CmpW'(req_i.position);
  assign fill_c  = psl_pkg::CmpW'(fill_q);
  assign pos_m1  = psl_pkg::AddrW'(req_i.position - psl_pkg::PosW'(1));
  assign fill_m1 = psl_pkg::AddrW'(fill_q - psl_pkg::CountW'(1));
  assign addr_p1 = addr_q + psl_pkg::AddrW'(1);
  assign addr_m1 = addr_q - psl_pkg::AddrW'(1);
  assign hit_pos = psl_pkg::PosW'({1'b0, addr_q} + (psl_pkg::AddrW + 1)'(1));

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    lim_d       = lim_q;
    fill_d      = fill_q;
    status_d    = status_q;
    found_d     = found_q;
    rec_ok_d    = rec_ok_q;
    key_d       = key_q;
    pay_d       = pay_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = addr_p1;
    ram_raddr   = addr_q;
    ram_wdata   = rd_entry;

    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (req_xfer) begin
          key_d    = req_i.key;
          pay_d    = req_i.payload;
          status_d = psl_pkg::StOk;
          found_d  = '0;
          rec_ok_d = 1'b0;
          lim_d    = pos_m1;
          state_d  = SReply;
          unique case (req_i.kind)
            psl_pkg::KindGet: begin
              if (pos_c == '0 || pos_c > fill_c) begin
                status_d = psl_pkg::StRange;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = pos_m1;
                state_d   = SGetWait;
              end
            end
            psl_pkg::KindInsert: begin
              if (pos_c == '0 || pos_c > fill_c + psl_pkg::CmpW'(1)) begin
                status_d = psl_pkg::StRange;
              end else if (fill_c >= psl_pkg::CmpW'(psl_pkg::Capacity)) begin
                status_d = psl_pkg::StFull;
              end else if (pos_c == fill_c + psl_pkg::CmpW'(1)) begin
                state_d = SInsPut;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = fill_m1;
                addr_d    = fill_m1;
                state_d   = SInsShift;
              end
            end
            psl_pkg::KindDelete: begin
              if (pos_c == '0 || pos_c > fill_c) begin
                status_d = psl_pkg::StRange;
              end else if (pos_c == fill_c) begin
                fill_d = fill_q - psl_pkg::CountW'(1);
              end else begin
                ram_re    = 1'b1;
                ram_raddr = psl_pkg::AddrW'(req_i.position);
                addr_d    = psl_pkg::AddrW'(req_i.position);
                state_d   = SDelShift;
              end
            end
            psl_pkg::KindSearch: begin
              if (fill_q == '0) begin
                status_d = psl_pkg::StMissing;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                addr_d    = '0;
                state_d   = SSearch;
              end
            end
            default: state_d = SReply;
          endcase
        end
      end
      SGetWait: begin
        rec_ok_d = 1'b1;
        state_d  = SReply;
      end
      SInsShift: begin
        // move the entry read last cycle up one place
        ram_we    = 1'b1;
        ram_waddr = addr_p1;
        ram_wdata = rd_entry;
        if (addr_q == lim_q) begin
          state_d = SInsPut;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = addr_m1;
          addr_d    = addr_m1;
        end
      end
      SInsPut: begin
        ram_we            = 1'b1;
        ram_waddr         = lim_q;
        ram_wdata.key     = key_q;
        ram_wdata.payload = pay_q;
        fill_d            = fill_q + psl_pkg::CountW'(1);
        state_d           = SReply;
      end
      SDelShift: begin
        // move the entry read last cycle down one place
        ram_we    = 1'b1;
        ram_waddr = addr_m1;
        ram_wdata = rd_entry;
        if (addr_q == fill_m1) begin
          fill_d  = fill_q - psl_pkg::CountW'(1);
          state_d = SReply;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = addr_p1;
          addr_d    = addr_p1;
        end
      end
      SSearch: begin
        if (rd_entry.key == key_q) begin
          found_d = hit_pos;
          state_d = SReply;
        end else if (addr_q == fill_m1) begin
          status_d = psl_pkg::StMissing;
          state_d  = SReply;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = addr_p1;
          addr_d    = addr_p1;
        end
      end
      SReply: begin
        if (slot_free) begin
          rsp_d.status         = status_q;
          rsp_d.found_position = found_q;
          rsp_d.record_key     = rec_ok_q ? rd_entry.key : '0;
          rsp_d.record_payload = rec_ok_q ? rd_entry.payload : '0;
          rsp_d.count          = psl_pkg::PosW'(fill_q);
          rsp_valid_d          = 1'b1;
          state_d              = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      fill_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    lim_q    <= lim_d;
    status_q <= status_d;
    found_q  <= found_d;
    rec_ok_q <= rec_ok_d;
    key_q    <= key_d;
    pay_q    <= pay_d;
    rsp_q    <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== tb/positional_sequential_list_test.sv =====
// self-checking testbench for the positional sequential list with random handshake gaps
module positional_sequential_list_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned HoldCycles  = 400;

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  psl_pkg::req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  psl_pkg::rsp_t rsp_o;

  positional_sequential_list uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o      (rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // list contents as the block should hold them
  logic signed [31:0] list_keys [psl_pkg::Capacity];
  logic [63:0]        list_payloads [psl_pkg::Capacity];
  int unsigned        list_len = 0;

  psl_pkg::req_t pending_reqs [$];
  psl_pkg::rsp_t expected_rsps [$];
  int unsigned planned_len = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned req_gap = 0;
  int unsigned req_calm = 0;
  int unsigned rsp_stall = 0;
  int unsigned rsp_calm = 0;

  function automatic psl_pkg::rsp_t apply_request(psl_pkg::req_t r);
    psl_pkg::rsp_t o;
    int unsigned   p;
    int unsigned   j;
    o = '0;
    p = r.position;
    case (r.kind)
      psl_pkg::KindGet: begin
        if (p < 1 || p > list_len) begin
          o.status = psl_pkg::StRange;
        end else begin
          o.status         = psl_pkg::StOk;
          o.record_key     = list_keys[p-1];
          o.record_payload = list_payloads[p-1];
        end
      end
      psl_pkg::KindInsert: begin
        if (p < 1 || p > list_len + 1) begin
          o.status = psl_pkg::StRange;
        end else if (list_len >= psl_pkg::Capacity) begin
          o.status = psl_pkg::StFull;
        end else begin
          for (j = list_len; j > p - 1; j--) begin
            list_keys[j]     = list_keys[j-1];
            list_payloads[j] = list_payloads[j-1];
          end
          list_keys[p-1]     = r.key;
          list_payloads[p-1] = r.payload;
          list_len++;
          o.status = psl_pkg::StOk;
        end
      end
      psl_pkg::KindDelete: begin
        if (p < 1 || p > list_len) begin
          o.status = psl_pkg::StRange;
        end else begin
          for (j = p - 1; j + 1 < list_len; j++) begin
            list_keys[j]     = list_keys[j+1];
            list_payloads[j] = list_payloads[j+1];
          end
          list_len--;
          o.status = psl_pkg::StOk;
        end
      end
      default: begin
        o.status = psl_pkg::StMissing;
        for (j = 0; j < list_len; j++) begin
          if (list_keys[j] == r.key) begin
            o.status         = psl_pkg::StOk;
            o.found_position = psl_pkg::PosW'(j + 1);
            break;
          end
        end
      end
    endcase
    o.count = psl_pkg::PosW'(list_len);
    return o;
  endfunction

  function automatic void check_result(psl_pkg::rsp_t got);
    psl_pkg::rsp_t want;
    if (expected_rsps.size() == 0) begin
      $error("result transfer with nothing expected: %p", got);
      mismatches++;
      return;
    end
    want = expected_rsps.pop_front();
    if (got.status !== want.status) begin
      $error("status expected %0d actual %0d", want.status, got.status);
      mismatches++;
    end
    if (got.found_position !== want.found_position) begin
      $error("found_position expected %0d actual %0d", want.found_position, got.found_position);
      mismatches++;
    end
    if (got.record_key !== want.record_key) begin
      $error("record_key expected %0d actual %0d", want.record_key, got.record_key);
      mismatches++;
    end
    if (got.record_payload !== want.record_payload) begin
      $error("record_payload expected %h actual %h", want.record_payload, got.record_payload);
      mismatches++;
    end
    if (got.count !== want.count) begin
      $error("count expected %0d actual %0d", want.count, got.count);
      mismatches++;
    end
  endfunction

  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 32'($urandom_range(0, 7)) - 32'd4;
    if (r == 5) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    return $urandom;
  endfunction

  task automatic push_item(input logic [1:0] kind, input int unsigned pos,
                           input logic signed [31:0] key, input logic [63:0] pay);
    psl_pkg::req_t r;
    r.kind     = kind;
    r.position = pos[psl_pkg::PosW-1:0];
    r.key      = key;
    r.payload  = pay;
    pending_reqs.push_back(r);
    if (kind == psl_pkg::KindInsert && pos >= 1 && pos <= planned_len + 1 &&
        planned_len < psl_pkg::Capacity)
      planned_len++;
    else if (kind == psl_pkg::KindDelete && pos >= 1 && pos <= planned_len)
      planned_len--;
  endtask

  task automatic push_random_op(input logic [1:0] kind);
    int unsigned p;
    if ($urandom_range(0, 99) < 12) p = $urandom_range(0, 127);
    else if (kind == psl_pkg::KindInsert) p = $urandom_range(1, planned_len + 1);
    else if (planned_len == 0) p = 1;
    else p = $urandom_range(1, planned_len);
    push_item(kind, p, pick_key(), {$urandom, $urandom});
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid_i || expected_rsps.size() != 0)
      @(negedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned g;
    if (!rst_ni) begin
      req_valid_i <= 1'b0;
      req_i       <= '0;
      req_gap     <= 0;
    end else if (req_valid_i && req_ready_o) begin
      expected_rsps.push_back(apply_request(req_i));
      if (req_calm > 0) req_calm <= req_calm - 1;
      else if ($urandom_range(0, 49) == 0) req_calm <= $urandom_range(20, 60);
      g = pick_gap(req_calm > 0);
      if (g == 0 && pending_reqs.size() != 0) begin
        req_i <= pending_reqs.pop_front();
      end else begin
        req_valid_i <= 1'b0;
        req_gap     <= g;
      end
    end else if (!req_valid_i) begin
      if (req_gap > 0) begin
        req_gap <= req_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        req_i       <= pending_reqs.pop_front();
        req_valid_i <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned g;
    if (!rst_ni) begin
      rsp_ready_i <= 1'b0;
      rsp_stall   <= 0;
    end else if (rsp_valid_o && rsp_ready_i) begin
      check_result(rsp_o);
      results_seen <= results_seen + 1;
      if (rsp_calm > 0) rsp_calm <= rsp_calm - 1;
      else if ($urandom_range(0, 49) == 0) rsp_calm <= $urandom_range(20, 60);
      g = pick_gap(rsp_calm > 0);
      // long hold-off so the block backs up and stalls its request side
      if (results_seen == 60 || results_seen == 300) g = HoldCycles;
      if (g != 0) begin
        rsp_ready_i <= 1'b0;
        rsp_stall   <= g;
      end
    end else if (!rsp_ready_i) begin
      if (rsp_stall > 1) rsp_stall <= rsp_stall - 1;
      else rsp_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned random_sent;
    int unsigned i;
    int unsigned first;
    random_sent = 0;
    first = 1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty list, range edges, extremes, duplicate keys
    push_item(psl_pkg::KindGet,    0,   32'sd0,         64'd0);
    push_item(psl_pkg::KindGet,    1,   32'sd0,         64'd0);
    push_item(psl_pkg::KindDelete, 1,   32'sd0,         64'd0);
    push_item(psl_pkg::KindSearch, 0,   32'sd5,         64'd0);
    push_item(psl_pkg::KindInsert, 0,   32'sd1,         64'd1);
    push_item(psl_pkg::KindInsert, 2,   32'sd1,         64'd1);
    push_item(psl_pkg::KindInsert, 1,   32'sh80000000,  64'd0);
    push_item(psl_pkg::KindInsert, 1,   32'sh7fffffff,  '1);
    push_item(psl_pkg::KindInsert, 3,   -32'sd1,        64'h5555_aaaa_5555_aaaa);
    push_item(psl_pkg::KindInsert, 2,   32'sh80000000,  64'haaaa_5555_aaaa_5555);
    push_item(psl_pkg::KindGet,    1,   32'sd0,         64'd0);
    push_item(psl_pkg::KindGet,    2,   32'sd0,         64'd0);
    push_item(psl_pkg::KindGet,    4,   32'sd0,         64'd0);
    push_item(psl_pkg::KindGet,    5,   32'sd0,         64'd0);
    push_item(psl_pkg::KindGet,    127, 32'sd0,         64'd0);
    push_item(psl_pkg::KindSearch, 0,   32'sh80000000,  64'd0);
    push_item(psl_pkg::KindSearch, 0,   -32'sd1,        64'd0);
    push_item(psl_pkg::KindSearch, 0,   32'sd12345,     64'd0);
    push_item(psl_pkg::KindInsert, 127, 32'sd7,         64'd7);
    push_item(psl_pkg::KindDelete, 0,   32'sd0,         64'd0);
    push_item(psl_pkg::KindDelete, 5,   32'sd0,         64'd0);
    push_item(psl_pkg::KindDelete, 4,   32'sd0,         64'd0);
    push_item(psl_pkg::KindDelete, 1,   32'sd0,         64'd0);
    push_item(psl_pkg::KindGet,    2,   32'sd0,         64'd0);
    push_item(psl_pkg::KindSearch, 0,   32'sh80000000,  64'd0);
    wait_drained();

    while (random_sent < RandomItems) begin
      case (first ? 0 : $urandom_range(0, 5))
        0: begin
          // fill to capacity, then refused inserts and walks over a full list
          while (planned_len < psl_pkg::Capacity) begin
            push_random_op(psl_pkg::KindInsert);
            random_sent++;
          end
          push_item(psl_pkg::KindInsert, psl_pkg::Capacity + 1, pick_key(),
                    {$urandom, $urandom});
          push_item(psl_pkg::KindInsert, 1, pick_key(), {$urandom, $urandom});
          push_item(psl_pkg::KindInsert, psl_pkg::Capacity + 2, pick_key(),
                    {$urandom, $urandom});
          push_item(psl_pkg::KindGet, psl_pkg::Capacity, 32'sd0, 64'd0);
          push_item(psl_pkg::KindGet, psl_pkg::Capacity + 1, 32'sd0, 64'd0);
          push_item(psl_pkg::KindSearch, 0, 32'sd999, 64'd0);
          push_item(psl_pkg::KindSearch, 0, pick_key(), 64'd0);
          push_item(psl_pkg::KindDelete, psl_pkg::Capacity, 32'sd0, 64'd0);
          random_sent += 8;
        end
        1: begin
          while (planned_len > 0) begin
            push_random_op(psl_pkg::KindDelete);
            random_sent++;
          end
          push_item(psl_pkg::KindGet, 1, 32'sd0, 64'd0);
          push_item(psl_pkg::KindSearch, 0, pick_key(), 64'd0);
          random_sent += 2;
        end
        default: begin
          for (i = 0; i < 30; i++) begin
            push_random_op(2'($urandom_range(0, 3)));
            random_sent++;
          end
        end
      endcase
      first = 0;
      if ($urandom_range(0, 2) == 0) wait_drained();
    end

    wait_drained();
    repeat (150) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/psl_pkg.sv
src/psl_ram.sv
src/positional_sequential_list.sv
tb/positional_sequential_list_test.sv
